>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the correction unit.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check violated");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/pcrc_pkg.sv
`default_nettype none

package pcrc_pkg;

    localparam int COEF_W     = 32;
    localparam int COL_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int FRAC_BITS  = 16;
    // Quotient bits kept by the divider; larger quotients are limited anyway.
    localparam int QUO_W      = 34;
    // Width of the signed sum of quotient and offset before clamping.
    localparam int SUM_W      = 36;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE  = 1'b1;

    localparam logic [COEF_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [QUO_W-1:0]  Q_LIMIT = QUO_W'(1) << (QUO_W - 1);

    typedef struct packed {
        logic [COEF_W-1:0] offset;
        logic [COEF_W-1:0] gain;
        logic [COEF_W-1:0] divisor;
    } t_coef;

    // Per-item data that rides alongside the divider.
    typedef struct packed {
        logic              nd;
        logic              nd_sat;
        logic [COEF_W-1:0] nd_val;
        logic              fault;
        logic              neg;
        logic [COEF_W-1:0] offset;
    } t_side;

    typedef struct packed {
        logic [COEF_W-1:0] value;
        logic              nd;
        logic              fault;
        logic              sat;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/pcrc_coef_mem.sv
`default_nettype none

module pcrc_coef_mem
    import pcrc_pkg::*;
#(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire t_coef             i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output t_coef                  o_rd_data
);

    t_coef r_mem [0:DEPTH-1];
    t_coef r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/pcrc_divider.sv
`default_nettype none

module pcrc_divider
    import pcrc_pkg::*;
#(
    parameter int PROD_W = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [PROD_W-1:0] i_prod,
    input  wire logic [COEF_W-1:0] i_divisor,
    input  wire t_side             i_side,
    output logic                   o_vld,
    output logic [QUO_W-1:0]       o_quotient,
    output logic                   o_ovf,
    output t_side                  o_side
);

    localparam int NUM_W = PROD_W + FRAC_BITS;

    typedef struct packed {
        logic [COEF_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic [QUO_W-1:0]  bits;
        logic [COEF_W-1:0] divisor;
        logic              ovf;
        t_side             side;
    } t_stage;

    logic   r_vld [0:QUO_W];
    t_stage r_st  [0:QUO_W];

    logic [NUM_W-1:0] w_num;
    logic [NUM_W-1:0] w_num_hi;

    // The dividend is the product scaled by 2^16. Everything above the kept
    // quotient bits is compared once: if it reaches the divisor, the quotient
    // is at least 2^34 and will be limited; otherwise the partial remainder
    // starts below the divisor as a restoring divider needs.
    assign w_num    = {i_prod, {FRAC_BITS{1'b0}}};
    assign w_num_hi = w_num >> QUO_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem     <= COEF_W'(w_num_hi);
            r_st[0].quo     <= '0;
            r_st[0].bits    <= w_num[QUO_W-1:0];
            r_st[0].divisor <= i_divisor;
            r_st[0].ovf     <= (w_num_hi >= NUM_W'(i_divisor));
            r_st[0].side    <= i_side;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar g = 1; g <= QUO_W; g++) begin : g_stage
        logic [COEF_W:0] w_trial;
        logic [COEF_W:0] w_diff;
        logic            w_take;

        assign w_trial = {r_st[g-1].rem, r_st[g-1].bits[QUO_W-1]};
        assign w_diff  = w_trial - {1'b0, r_st[g-1].divisor};
        assign w_take  = (w_trial >= {1'b0, r_st[g-1].divisor});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g].rem     <= w_take ? w_diff[COEF_W-1:0] : w_trial[COEF_W-1:0];
                r_st[g].quo     <= {r_st[g-1].quo[QUO_W-2:0], w_take};
                r_st[g].bits    <= {r_st[g-1].bits[QUO_W-2:0], 1'b0};
                r_st[g].divisor <= r_st[g-1].divisor;
                r_st[g].ovf     <= r_st[g-1].ovf;
                r_st[g].side    <= r_st[g-1].side;
            end
        end
    end

    assign o_vld      = r_vld[QUO_W];
    assign o_quotient = r_st[QUO_W].quo;
    assign o_ovf      = r_st[QUO_W].ovf;
    assign o_side     = r_st[QUO_W].side;

endmodule

`default_nettype wire

>>> rtl/pcrc_out_buf.sv
`default_nettype none
`include "assert_macros.svh"

module pcrc_out_buf
    import pcrc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_room,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    localparam logic [1:0] CNT_FULL = 2'd2;

    t_result    r_entry [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign n_count = r_count + {1'b0, i_push} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    // Room depends on the stored count only, so the receiver's ready never
    // reaches the input side in the same cycle.
    assign o_room  = (r_count != CNT_FULL);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_entry[r_rd_ptr];

    `ASSERT_IMPLIES(a_no_push_when_full, i_clk, i_rst_n, r_count == CNT_FULL, !i_push)
    `ASSERT_ALWAYS(a_count_bounded, i_clk, i_rst_n, r_count != 2'd3)

endmodule

`default_nettype wire

>>> rtl/per_column_radiometric_correct_unit.sv
// Per-column gain and offset correction of raw pixels.
// Input channel (i_valid / o_ready) takes two kinds of item. A load item
// (opcode 0) writes offset, gain and divisor of one column into the
// coefficient memory and gives no result. A pixel item (opcode 1) reads its
// column and gives exactly one result on the output channel
// (o_valid / i_ready): gain * value / divisor + offset in signed Q16.16,
// clamped, with no-data and fault flags (zero divisor, column out of range).
// A pixel passes the coefficient read, product register and divider into a
// two-entry output buffer in front of the receiver. While o_ready is high,
// one item is accepted per cycle: the coefficient memory is read once per
// item and the 34-stage divider takes one new quotient per cycle. The input
// stays ready while one result waits; only with two results waiting does
// o_ready drop, and the whole pipeline then holds until one is taken.
// Reset clears the pipeline, the output buffer and both configuration
// registers. The coefficient memory is not cleared: load a column before
// sending its pixels. Configuration is written through i_cfg_wr_en, by the
// user only while the unit is idle; the unit itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module per_column_radiometric_correct_unit
    import pcrc_pkg::*;
#(
    parameter int MAX_COLUMNS = 8192,
    parameter int PIXEL_BITS  = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,

    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_opcode,
    input  wire logic [COL_W-1:0]             i_column,
    input  wire logic [PIXEL_BITS-1:0]        i_pixel_value,
    input  wire logic signed [COEF_W-1:0]     i_coef_offset,
    input  wire logic signed [COEF_W-1:0]     i_coef_gain,
    input  wire logic [COEF_W-1:0]            i_coef_divisor,

    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [COEF_W-1:0]          o_corrected_value,
    output logic                              o_was_nodata,
    output logic                              o_divide_fault,
    output logic                              o_saturated
);

    localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int PROD_W = COEF_W + PIXEL_BITS;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(VAL_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

    // Configuration
    logic                  r_nodata_enable;
    logic [CFG_DATA_W-1:0] r_nodata_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodata_enable <= 1'b0;
            r_nodata_value  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_NODATA_ENABLE: r_nodata_enable <= i_cfg_data[0];
                CFG_NODATA_VALUE:  r_nodata_value  <= i_cfg_data;
            endcase
        end
    end

    // Accept and table access
    logic        w_room;
    logic        w_accept;
    logic        w_is_pixel;
    logic        w_col_ok;
    logic        w_nd_match;
    logic [63:0] w_nd_wide;
    logic        w_nd_sat;
    t_coef       w_wr_coef;
    t_coef       w_rd_coef;

    assign o_ready    = w_room;
    assign w_accept   = i_valid && w_room;
    assign w_is_pixel = (i_opcode == OP_PIXEL);
    assign w_col_ok   = (32'(i_column) < 32'(MAX_COLUMNS));
    assign w_nd_match = r_nodata_enable && (32'(i_pixel_value) == 32'(r_nodata_value));
    assign w_nd_wide  = 64'(i_pixel_value) << FRAC_BITS;
    assign w_nd_sat   = (w_nd_wide > 64'(VAL_MAX));

    assign w_wr_coef.offset  = i_coef_offset;
    assign w_wr_coef.gain    = i_coef_gain;
    assign w_wr_coef.divisor = i_coef_divisor;

    // A load writes at its accepting edge and a later pixel reads at its own
    // edge, so the read always sees the newest triple without forwarding.
    pcrc_coef_mem #(
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (ADDR_W)
    ) u_coef_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && !w_is_pixel && w_col_ok),
        .i_wr_addr (ADDR_W'(i_column)),
        .i_wr_data (w_wr_coef),
        .i_rd_en   (w_room),
        .i_rd_addr (ADDR_W'(i_column)),
        .o_rd_data (w_rd_coef)
    );

    logic                  r_s1_vld;
    logic                  r_s1_col_ok;
    logic                  r_s1_nd;
    logic                  r_s1_nd_sat;
    logic [COEF_W-1:0]     r_s1_nd_val;
    logic [PIXEL_BITS-1:0] r_s1_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_room) begin
            r_s1_vld <= w_accept && w_is_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_room) begin
            r_s1_col_ok <= w_col_ok;
            r_s1_nd     <= w_nd_match;
            r_s1_nd_sat <= w_nd_sat;
            r_s1_nd_val <= w_nd_sat ? VAL_MAX : w_nd_wide[COEF_W-1:0];
            r_s1_pixel  <= i_pixel_value;
        end
    end

    // Multiply the gain magnitude by the pixel
    logic              w_gain_neg;
    logic [COEF_W-1:0] w_gain_mag;

    assign w_gain_neg = w_rd_coef.gain[COEF_W-1];
    assign w_gain_mag = w_gain_neg ? (COEF_W'(0) - w_rd_coef.gain) : w_rd_coef.gain;

    logic              r_s2_vld;
    logic [PROD_W-1:0] r_s2_prod;
    logic [COEF_W-1:0] r_s2_div;
    t_side             r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_room) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_room) begin
            r_s2_prod <= PROD_W'(w_gain_mag) * PROD_W'(r_s1_pixel);
            r_s2_div  <= w_rd_coef.divisor;
            r_s2_side.nd     <= r_s1_nd;
            r_s2_side.nd_sat <= r_s1_nd_sat;
            r_s2_side.nd_val <= r_s1_nd_val;
            // A column beyond the table is a fault, whatever the memory returns.
            r_s2_side.fault  <= !r_s1_col_ok || (w_rd_coef.divisor == '0);
            r_s2_side.neg    <= w_gain_neg;
            r_s2_side.offset <= w_rd_coef.offset;
        end
    end

    // Divide
    logic             w_div_vld;
    logic [QUO_W-1:0] w_quo;
    logic             w_ovf;
    t_side            w_side;

    pcrc_divider #(
        .PROD_W (PROD_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_room),
        .i_vld      (r_s2_vld),
        .i_prod     (r_s2_prod),
        .i_divisor  (r_s2_div),
        .i_side     (r_s2_side),
        .o_vld      (w_div_vld),
        .o_quotient (w_quo),
        .o_ovf      (w_ovf),
        .o_side     (w_side)
    );

    // Apply sign, add offset and clamp
    logic [QUO_W-1:0]        w_quo_lim;
    logic signed [SUM_W-1:0] w_off_x;
    logic signed [SUM_W-1:0] w_quo_x;
    logic signed [SUM_W-1:0] w_sum;
    t_result                 w_result;
    t_result                 w_out;

    assign w_quo_lim = (w_ovf || (w_quo > Q_LIMIT)) ? Q_LIMIT : w_quo;
    assign w_off_x   = {{(SUM_W - COEF_W){w_side.offset[COEF_W-1]}}, w_side.offset};
    assign w_quo_x   = {{(SUM_W - QUO_W){1'b0}}, w_quo_lim};
    assign w_sum     = w_side.neg ? (w_off_x - w_quo_x) : (w_off_x + w_quo_x);

    always_comb begin
        w_result.nd    = 1'b0;
        w_result.fault = 1'b0;
        w_result.sat   = 1'b0;
        w_result.value = w_sum[COEF_W-1:0];
        if (w_side.nd) begin
            w_result.nd    = 1'b1;
            w_result.sat   = w_side.nd_sat;
            w_result.value = w_side.nd_val;
        end else if (w_side.fault) begin
            w_result.fault = 1'b1;
            w_result.value = '0;
        end else if (w_sum > SUM_MAX) begin
            w_result.sat   = 1'b1;
            w_result.value = VAL_MAX;
        end else if (w_sum < SUM_MIN) begin
            w_result.sat   = 1'b1;
            w_result.value = VAL_MIN;
        end
    end

    pcrc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_room && w_div_vld),
        .i_data  (w_result),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out)
    );

    assign o_corrected_value = w_out.value;
    assign o_was_nodata      = w_out.nd;
    assign o_divide_fault    = w_out.fault;
    assign o_saturated       = w_out.sat;

    `ASSERT_IMPLIES(a_nd_fault_excl, i_clk, i_rst_n, o_valid, !(o_was_nodata && o_divide_fault))
    `ASSERT_IMPLIES(a_fault_zero, i_clk, i_rst_n, o_valid && o_divide_fault, (o_corrected_value == '0) && !o_saturated)
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_room, $stable(r_s1_vld) && $stable(r_s2_vld) && $stable(w_div_vld))

endmodule

`default_nettype wire
